// ===== sv/binary_mask_cross_extent_probe_assert.svh =====
// Assertion macros shared by the extent probe RTL.
`ifndef BINARY_MASK_CROSS_EXTENT_PROBE_ASSERT_SVH
`define BINARY_MASK_CROSS_EXTENT_PROBE_ASSERT_SVH

// Same-cycle implication, clocked on clk_i and disabled during reset.
`define BMCEP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and disabled during reset.
`define BMCEP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bmcep_pkg.sv =====
// Shared constants and types of the cross extent probe.
package bmcep_pkg;

  localparam int COORD_W = 8;
  localparam int PIX_W = 8;
  localparam int DIM_W = 9;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = DIM_W;

  localparam int DEF_MAX_COLS = 256;
  localparam int DEF_MAX_ROWS = 256;
  localparam int COORD_SPAN = 1 << COORD_W;

  localparam logic [PIX_W-1:0] FG_LEVEL = 8'hFF;
  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    DIR_LEFT,
    DIR_UP,
    DIR_RIGHT,
    DIR_DOWN
  } dir_e;

endpackage

// ===== sv/bmcep_in_if.sv =====
// Input channel: pixel writes and extent queries.
interface bmcep_in_if;
  import bmcep_pkg::*;

  logic               valid;
  logic               ready;
  logic               kind;
  logic [COORD_W-1:0] query_x;
  logic [COORD_W-1:0] query_y;
  logic [PIX_W-1:0]   pixel_value;

  modport source (output valid, kind, query_x, query_y, pixel_value, input ready);
  modport sink   (input valid, kind, query_x, query_y, pixel_value, output ready);
endinterface

// ===== sv/bmcep_out_if.sv =====
// Output channel: extent rectangles and status flags.
interface bmcep_out_if;
  import bmcep_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] rect_x;
  logic [COORD_W-1:0] rect_y;
  logic [COORD_W-1:0] rect_width;
  logic [COORD_W-1:0] rect_height;
  logic               on_boundary;
  logic               out_of_range;

  modport source (output valid, rect_x, rect_y, rect_width, rect_height, on_boundary,
                  out_of_range, input ready);
  modport sink   (input valid, rect_x, rect_y, rect_width, rect_height, on_boundary,
                  out_of_range, output ready);
endinterface

// ===== sv/binary_mask_cross_extent_probe.sv =====
// Cross extent probe: a pixel write gives no word. A query goes straight from the check to
// its result when out of range, on a boundary or not foreground; otherwise it first walks
// left, up, right and down from the center, stopping each walk at an edge or background.
// The four walks share the single-port pixel memory and read one pixel per cycle.
// The result sits in an output register, so the next word is taken while it waits.
// Reset clears control and sets both image size registers to 256; pixels stay unset.
module binary_mask_cross_extent_probe #(
  parameter int MAX_COLS = bmcep_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = bmcep_pkg::DEF_MAX_ROWS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bmcep_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bmcep_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  bmcep_in_if.sink                           in_i,
  bmcep_out_if.source                        out_o
);
  import bmcep_pkg::*;

  // Coordinates never exceed 255, so only that part of a larger store is reachable.
  localparam int ColsUsed = (MAX_COLS < COORD_SPAN) ? MAX_COLS : COORD_SPAN;
  localparam int RowsUsed = (MAX_ROWS < COORD_SPAN) ? MAX_ROWS : COORD_SPAN;
  localparam int ColAw = $clog2(ColsUsed);
  localparam int RowAw = $clog2(RowsUsed);
  localparam int AddrW = ColAw + RowAw;
  localparam int Depth = 1 << AddrW;

  state_e             state_q, state_d;
  dir_e               dir_q, dir_d;
  logic               first_q, first_d;
  logic [COORD_W-1:0] cur_q, cur_d;
  logic [COORD_W-1:0] qx_q, qx_d, qy_q, qy_d;
  logic [COORD_W-1:0] l_q, l_d, t_q, t_d, r_q, r_d, b_q, b_d;
  logic               oor_q, oor_d, bnd_q, bnd_d;
  logic [DIM_W-1:0]   cfg_w_q, cfg_h_q;
  logic               out_vld_q, out_vld_d;
  logic [COORD_W-1:0] ox_q, oy_q, ow_q, oh_q;
  logic               ob_q, oo_q;

  logic [PIX_W-1:0]   pix_mem [Depth];
  logic [PIX_W-1:0]   rd_data_q;
  logic [AddrW-1:0]   mem_addr;
  logic               mem_we;

  logic [DIM_W-1:0]   w_lim, h_lim, w_last, h_last;
  logic               in_acc, out_load, stop, at_edge, fg, query_oor, wr_in_store;
  logic               query_acc, walk_h, walk_v, out_rect_zero;
  logic [COORD_W-1:0] step_pos;

  // Image size in use: register value limited to 1 .. used store size.
  always_comb begin
    if (cfg_w_q == '0) begin
      w_lim = DIM_W'(1);
    end else if (cfg_w_q > DIM_W'(ColsUsed)) begin
      w_lim = DIM_W'(ColsUsed);
    end else begin
      w_lim = cfg_w_q;
    end
    if (cfg_h_q == '0) begin
      h_lim = DIM_W'(1);
    end else if (cfg_h_q > DIM_W'(RowsUsed)) begin
      h_lim = DIM_W'(RowsUsed);
    end else begin
      h_lim = cfg_h_q;
    end
    w_last = w_lim - DIM_W'(1);
    h_last = h_lim - DIM_W'(1);
  end

  assign in_acc = in_i.valid && in_i.ready;
  assign query_acc = in_acc && (in_i.kind == KIND_QUERY);
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_load = (state_q == ST_DONE) && (!out_vld_q || out_o.ready);
  assign query_oor = ({1'b0, qx_q} >= w_lim) || ({1'b0, qy_q} >= h_lim);
  assign wr_in_store = (32'(in_i.query_x) < 32'(MAX_COLS))
                    && (32'(in_i.query_y) < 32'(MAX_ROWS));

  // Walk step: the first cycle of each direction stands on the center, which is
  // already known to be foreground, so no memory data is needed there.
  always_comb begin
    fg = first_q || (rd_data_q == FG_LEVEL);
    case (dir_q)
      DIR_LEFT:  at_edge = (cur_q == '0);
      DIR_UP:    at_edge = (cur_q == '0);
      DIR_RIGHT: at_edge = (cur_q == w_last[COORD_W-1:0]);
      DIR_DOWN:  at_edge = (cur_q == h_last[COORD_W-1:0]);
      default:   at_edge = 1'b1;
    endcase
    stop = at_edge || !fg;
    if (dir_q == DIR_LEFT || dir_q == DIR_UP) begin
      step_pos = cur_q - COORD_W'(1);
    end else begin
      step_pos = cur_q + COORD_W'(1);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (query_acc) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (query_oor || rd_data_q != FG_LEVEL) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (stop && dir_q == DIR_DOWN) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    dir_d = dir_q;
    first_d = first_q;
    cur_d = cur_q;
    qx_d = qx_q;
    qy_d = qy_q;
    l_d = l_q;
    t_d = t_q;
    r_d = r_q;
    b_d = b_q;
    oor_d = oor_q;
    bnd_d = bnd_q;
    mem_we = 1'b0;
    mem_addr = {in_i.query_y[RowAw-1:0], in_i.query_x[ColAw-1:0]};
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          qx_d = in_i.query_x;
          qy_d = in_i.query_y;
          mem_we = (in_i.kind == KIND_WRITE) && wr_in_store;
        end
      end
      ST_CHECK: begin
        oor_d = query_oor;
        bnd_d = !query_oor && (rd_data_q == '0);
        l_d = qx_q;
        r_d = qx_q;
        t_d = qy_q;
        b_d = qy_q;
        dir_d = DIR_LEFT;
        first_d = 1'b1;
        cur_d = qx_q;
      end
      ST_WALK: begin
        if (stop) begin
          first_d = 1'b1;
          case (dir_q)
            DIR_LEFT: begin
              l_d = cur_q;
              dir_d = DIR_UP;
              cur_d = qy_q;
            end
            DIR_UP: begin
              t_d = cur_q;
              dir_d = DIR_RIGHT;
              cur_d = qx_q;
            end
            DIR_RIGHT: begin
              r_d = cur_q;
              dir_d = DIR_DOWN;
              cur_d = qy_q;
            end
            default: begin
              b_d = cur_q;
            end
          endcase
        end else begin
          first_d = 1'b0;
          cur_d = step_pos;
        end
        // Read the pixel under the next position; ignored when the walk stops.
        if (dir_q == DIR_LEFT || dir_q == DIR_RIGHT) begin
          mem_addr = {qy_q[RowAw-1:0], step_pos[ColAw-1:0]};
        end else begin
          mem_addr = {step_pos[RowAw-1:0], qx_q[ColAw-1:0]};
        end
      end
      default: ;
    endcase

    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  // Writes happen only for a write word taken in idle; a query reads its center as it is taken
  // in idle and reads on while busy, so a read never meets a pending write to the same pixel.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pix_mem[mem_addr] <= in_i.pixel_value;
    end
    rd_data_q <= pix_mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dir_q <= DIR_LEFT;
      first_q <= 1'b1;
      out_vld_q <= 1'b0;
      cfg_w_q <= DIM_RESET;
      cfg_h_q <= DIM_RESET;
    end else begin
      state_q <= state_d;
      dir_q <= dir_d;
      first_q <= first_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i && cfg_idx_i == CFG_IMAGE_WIDTH) begin
        cfg_w_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_idx_i == CFG_IMAGE_HEIGHT) begin
        cfg_h_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    qx_q <= qx_d;
    qy_q <= qy_d;
    l_q <= l_d;
    t_q <= t_d;
    r_q <= r_d;
    b_q <= b_d;
    oor_q <= oor_d;
    bnd_q <= bnd_d;
    if (out_load) begin
      if (oor_q || bnd_q) begin
        ox_q <= '0;
        oy_q <= '0;
        ow_q <= '0;
        oh_q <= '0;
      end else begin
        ox_q <= l_q;
        oy_q <= t_q;
        ow_q <= r_q - l_q;
        oh_q <= b_q - t_q;
      end
      ob_q <= bnd_q;
      oo_q <= oor_q;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.rect_x = ox_q;
  assign out_o.rect_y = oy_q;
  assign out_o.rect_width = ow_q;
  assign out_o.rect_height = oh_q;
  assign out_o.on_boundary = ob_q;
  assign out_o.out_of_range = oo_q;

  assign walk_h = (state_q == ST_WALK) && (dir_q == DIR_LEFT || dir_q == DIR_RIGHT);
  assign walk_v = (state_q == ST_WALK) && (dir_q == DIR_UP || dir_q == DIR_DOWN);
  assign out_rect_zero = ({ob_q, ox_q, oy_q, ow_q, oh_q} == '0);

`include "binary_mask_cross_extent_probe_assert.svh"

  `BMCEP_ASSERT_NXT(a_query_to_check, query_acc, state_q == ST_CHECK, "query not checked")
  `BMCEP_ASSERT_IMP(a_walk_in_image, walk_h, {1'b0, cur_q} <= w_last, "row walk left image")
  `BMCEP_ASSERT_IMP(a_walk_in_rows, walk_v, {1'b0, cur_q} <= h_last, "column walk left image")
  `BMCEP_ASSERT_IMP(a_oor_zero_rect, out_vld_q && oo_q, out_rect_zero, "out of range word not empty")
  `BMCEP_ASSERT_IMP(a_write_idle_only, mem_we, state_q == ST_IDLE, "pixel write outside idle")

endmodule
